>>> hw/rtl/tmps_pkg.sv
package tmps_pkg;

  localparam int SUM_W            = 48;
  localparam int VALUE_W          = 32;
  localparam int ROW_COUNT_W      = 9;
  localparam int DEFAULT_MAX_ROWS = 256;
  localparam int APB_DATA_W       = 32;
  localparam int APB_ADDR_W       = 3;
  localparam int QUEUE_CNT_W      = 2;

  // word index of the register within the APB window
  localparam logic REG_ROW_COUNT = 1'b0;

  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [VALUE_W-1:0] value_t;

  // per-entry control carried from the read stage to the update stage
  typedef struct packed {
    logic   row_zero;
    logic   col_zero;
    logic   diag;
    logic   last_row;
    value_t value;
  } cell_ctl_t;

  typedef struct packed {
    sum_t high;
    sum_t low;
  } result_t;

  typedef struct packed {
    logic                   full;
    logic [QUEUE_CNT_W-1:0] count;
  } queue_status_t;

endpackage

>>> hw/rtl/tmps_row_mem.sv
module tmps_row_mem
  import tmps_pkg::*;
#(
  parameter int DEPTH = DEFAULT_MAX_ROWS,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  sum_t          wdata,
  input  logic [AW-1:0] raddr,
  output sum_t          rdata
);

  sum_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/tmps_result_queue.sv
module tmps_result_queue
  import tmps_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  result_t       push_data,
  input  logic          ready,
  output logic          valid,
  output result_t       head,
  output queue_status_t status
);

  result_t                slots [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic [QUEUE_CNT_W-1:0] count_next;
  logic                   pop;

  assign valid = (count != '0);
  assign pop   = valid && ready;
  assign head  = slots[rd_ptr];

  assign status.count = count;
  assign status.full  = (count == QUEUE_CNT_W'(2));

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + QUEUE_CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

>>> hw/rtl/triangle_max_min_path_sum_unit.sv
// The last entry of a triangle is registered into the update stage; its result is then registered in the output queue.
// Throughput: one entry per cycle while in_ready is high; each entry does one read and one write on the two row
// memories, with the write of column 0 in row 0 forwarded to the next entry's read of column 0.
// A two-deep result queue keeps input flowing while a result waits on out_ready.
// Reset (rst, synchronous, active high): row_count = 1, position and extremes cleared,
// row memories keep their contents and are not cleared.
module triangle_max_min_path_sum_unit
  import tmps_pkg::*;
#(
  parameter int MAX_ROWS = DEFAULT_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  value_t                entry_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sum_t                  max_path_sum,
  output sum_t                  min_path_sum
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (AW + 1 > ROW_COUNT_W) ? AW + 1 : ROW_COUNT_W;
  localparam logic [CW-1:0] MAX_ROWS_C = CW'(MAX_ROWS);

  logic [ROW_COUNT_W-1:0] row_count;
  logic                   cfg_write;

  logic [AW-1:0] current_row;
  logic [AW-1:0] current_column;
  logic [AW-1:0] current_row_next;
  logic [AW-1:0] current_column_next;
  logic [CW-1:0] eff_rows;
  logic          last_row;
  logic          diag;
  logic          in_fire;

  logic          s1_valid;
  cell_ctl_t     s1_ctl;
  logic [AW-1:0] s1_col;
  logic          fwd_hit;
  sum_t          fwd_high;
  sum_t          fwd_low;

  sum_t rd_high;
  sum_t rd_low;
  sum_t old_high;
  sum_t old_low;
  sum_t value_ext;
  sum_t new_high;
  sum_t new_low;
  sum_t saved_left_high;
  sum_t saved_left_low;
  sum_t running_max;
  sum_t running_min;
  sum_t running_max_next;
  sum_t running_min_next;

  logic          emit;
  logic          out_pop;
  logic [2:0]    slots_used;
  result_t       push_data;
  result_t       head;
  queue_status_t q_status;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[APB_ADDR_W-1] == REG_ROW_COUNT);

  always_comb begin
    prdata = '0;
    if (paddr[APB_ADDR_W-1] == REG_ROW_COUNT) begin
      prdata = APB_DATA_W'(row_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROW_COUNT_W'(1);
    end else if (cfg_write) begin
      row_count <= pwdata[ROW_COUNT_W-1:0];
    end
  end

  // read stage: position tracking and row memory read
  always_comb begin
    if (row_count == '0) begin
      eff_rows = CW'(1);
    end else if (CW'(row_count) > MAX_ROWS_C) begin
      eff_rows = MAX_ROWS_C;
    end else begin
      eff_rows = CW'(row_count);
    end
  end

  assign last_row = (CW'(current_row) + CW'(1)) >= eff_rows;
  assign diag     = current_column >= current_row;

  // reserve a queue slot for every entry in flight
  assign out_pop    = out_valid && out_ready;
  assign slots_used = 3'(q_status.count) + 3'(emit) - 3'(out_pop);
  assign in_ready   = slots_used <= 3'd1;
  assign in_fire    = in_valid && in_ready;

  always_comb begin
    current_row_next    = current_row;
    current_column_next = current_column;
    if (in_fire) begin
      if (diag) begin
        current_column_next = '0;
        current_row_next    = last_row ? '0 : current_row + AW'(1);
      end else begin
        current_column_next = current_column + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_row    <= '0;
      current_column <= '0;
      s1_valid       <= 1'b0;
      fwd_hit        <= 1'b0;
    end else begin
      current_row    <= current_row_next;
      current_column <= current_column_next;
      s1_valid       <= in_fire;
      fwd_hit        <= in_fire && s1_valid && (s1_col == current_column);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col          <= current_column;
      s1_ctl.row_zero <= (current_row == '0);
      s1_ctl.col_zero <= (current_column == '0);
      s1_ctl.diag     <= diag;
      s1_ctl.last_row <= last_row;
      s1_ctl.value    <= entry_value;
    end
    fwd_high <= new_high;
    fwd_low  <= new_low;
  end

  tmps_row_mem #(.DEPTH(MAX_ROWS), .AW(AW)) u_high_mem (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (new_high),
    .raddr (current_column),
    .rdata (rd_high)
  );

  tmps_row_mem #(.DEPTH(MAX_ROWS), .AW(AW)) u_low_mem (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (new_low),
    .raddr (current_column),
    .rdata (rd_low)
  );

  // update stage
  assign old_high  = fwd_hit ? fwd_high : rd_high;
  assign old_low   = fwd_hit ? fwd_low : rd_low;
  assign value_ext = {{(SUM_W - VALUE_W){s1_ctl.value[VALUE_W-1]}}, s1_ctl.value};

  always_comb begin
    priority if (s1_ctl.row_zero) begin
      new_high = value_ext;
      new_low  = value_ext;
    end else if (s1_ctl.col_zero) begin
      new_high = old_high + value_ext;
      new_low  = old_low + value_ext;
    end else if (s1_ctl.diag) begin
      new_high = saved_left_high + value_ext;
      new_low  = saved_left_low + value_ext;
    end else begin
      new_high = ((saved_left_high > old_high) ? saved_left_high : old_high) + value_ext;
      new_low  = ((saved_left_low < old_low) ? saved_left_low : old_low) + value_ext;
    end
  end

  always_comb begin
    running_max_next = running_max;
    running_min_next = running_min;
    if (s1_valid && s1_ctl.last_row) begin
      if (s1_ctl.col_zero) begin
        running_max_next = new_high;
        running_min_next = new_low;
      end else begin
        if (new_high > running_max) running_max_next = new_high;
        if (new_low < running_min) running_min_next = new_low;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saved_left_high <= '0;
      saved_left_low  <= '0;
      running_max     <= '0;
      running_min     <= '0;
    end else begin
      running_max <= running_max_next;
      running_min <= running_min_next;
      if (s1_valid) begin
        saved_left_high <= old_high;
        saved_left_low  <= old_low;
      end
    end
  end

  assign emit           = s1_valid && s1_ctl.diag && s1_ctl.last_row;
  assign push_data.high = running_max_next;
  assign push_data.low  = running_min_next;

  tmps_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data (push_data),
    .ready     (out_ready),
    .valid     (out_valid),
    .head      (head),
    .status    (q_status)
  );

  assign max_path_sum = head.high;
  assign min_path_sum = head.low;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (emit && q_status.full) |-> out_ready)
    else $error("result queue overflow");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(emit))
    else $error("result without a final entry");

  // only a column 0 read can follow a column 0 write of row 0
  a_fwd_row_one: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> (s1_valid && s1_ctl.col_zero))
    else $error("forwarding to a column other than zero");

  a_stage_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted entry lost before update");
`endif

endmodule
